// ----- hdl/ramped_matrix_mixer_unit_defines.svh -----
// Assertion macros for the mixer
`ifndef RAMPED_MATRIX_MIXER_UNIT_DEFINES_SVH
`define RAMPED_MATRIX_MIXER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/rmm_pkg.sv -----
package rmm_pkg;
    localparam int MaxInputs  = 8;
    localparam int MaxOutputs = 8;
    localparam int Cells      = MaxInputs * MaxOutputs;
    localparam int CellW      = $clog2(Cells);
    localparam int InW        = 3;
    localparam int OutW       = 3;
    localparam int CntW       = 4;
    // cell word: target 24, current 40, step 40, steps_left 16
    localparam int CellDataW  = 24 + 40 + 40 + 16;

    localparam logic [1:0] FuncSample = 2'd0;
    localparam logic [1:0] FuncSetGain = 2'd1;
    localparam logic [1:0] FuncClear  = 2'd2;

    localparam logic [1:0] CfgRamp = 2'd0;
    localparam logic [1:0] CfgIns  = 2'd1;
    localparam logic [1:0] CfgOuts = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_CALC, S_DIV, S_WR, S_MUL, S_ACC, S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [23:0] target;
        logic signed [39:0] current;
        logic signed [39:0] step;
        logic [15:0]        left;
    } t_cell;

    typedef struct packed {
        logic        start;
        logic [40:0] dividend; // magnitude
        logic [15:0] divisor;
    } t_div_req;

    function automatic logic [CntW-1:0] clamp_cnt(input logic [3:0] v, input int mx);
        logic [CntW-1:0] r;
        if (v == 4'd0) r = CntW'(1);
        else if (int'(v) > mx) r = CntW'(mx);
        else r = v;
        return r;
    endfunction
endpackage

// ----- hdl/ramped_matrix_mixer_unit.sv -----
// Sample beat: each active output steps through read, wait, calc, multiply and
//   accumulate; a frame end then emits one result beat per active output. Set gain uses
//   the bit-serial divider (one quotient bit per cycle, 41 bits) unless the ramp is zero.
// Clear walks every cell; a cell whose target changes is retargeted to zero, others are left.
// Throughput is one beat at a time: o_ready is high only when idle with no result pending.
// Reset: synchronous active low; a clear pass over all 64 cells zeroes the cell memory, no beat taken.
`include "ramped_matrix_mixer_unit_defines.svh"
module ramped_matrix_mixer_unit import rmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_in_index,
    input  logic [2:0]         i_out_index,
    input  logic signed [23:0] i_sample,
    input  logic signed [23:0] i_gain,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_channel,
    output logic signed [23:0] o_mixed_sample,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam logic signed [40:0] G40Max = 41'sd549755813887;
    localparam logic signed [40:0] G40Min = -41'sd549755813888;
    localparam logic signed [48:0] AccMax = 49'sd140737488355327;
    localparam logic signed [48:0] AccMin = -49'sd140737488355328;

    t_state r_state, n_state;
    logic [15:0] r_ramp;
    logic [3:0]  r_ins, r_outs;
    logic [1:0]  r_func;
    logic signed [23:0] r_smp, r_gin;
    logic        r_fend;
    logic [CellW-1:0] r_cell, n_cell;
    logic [2:0]  r_o, n_o;
    t_cell       r_cw, n_cw;
    logic signed [23:0] r_g, n_g;
    logic signed [47:0] r_prod;
    logic signed [47:0] r_acc [MaxOutputs];
    logic        r_neg, n_neg;
    logic        r_ovalid;
    logic [2:0]  r_ch;
    logic signed [23:0] r_mix;
    logic        r_last;

    logic [CntW-1:0] nin, nout;
    logic [CellDataW-1:0] rdata;
    t_cell       rd;
    logic        we;
    logic [CellW-1:0] raddr;
    t_div_req    dreq;
    logic        dbusy;
    logic [40:0] dquot;
    logic signed [40:0] diff, qs;
    logic signed [48:0] acc_sum;
    logic        take;

    assign nin = clamp_cnt(r_ins, MaxInputs);
    assign nout = clamp_cnt(r_outs, MaxOutputs);
    assign rd = t_cell'(rdata);
    assign take = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    rmm_ram #(.Width(CellDataW), .Depth(Cells)) u_cells (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_cell), .i_wdata(n_cw),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    rmm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_busy(dbusy), .o_quot(dquot)
    );

    // new target against the gain just read from the cell
    assign diff = 41'(signed'({((r_func == FuncClear) ? 24'sd0 : r_gin), 16'd0}))
                - 41'(rd.current);
    assign qs = r_neg ? -$signed(dquot) : $signed(dquot);
    assign acc_sum = 49'(r_acc[r_o]) + 49'(r_prod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cell == CellW'(Cells - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (take) begin
                    if (i_func == FuncSample) begin
                        n_state = ({1'b0, i_in_index} < nin) ? S_RD
                                : (i_frame_end ? S_EMIT : S_IDLE);
                    end else if (i_func == FuncSetGain) begin
                        n_state = ({1'b0, i_in_index} < nin && {1'b0, i_out_index} < nout)
                                ? S_RD : S_IDLE;
                    end else if (i_func == FuncClear) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_CALC;
            S_CALC: begin
                if (r_func == FuncSample) n_state = S_MUL;
                else if (rd.target == ((r_func == FuncClear) ? 24'sd0 : r_gin))
                    n_state = (r_func == FuncClear && r_cell != CellW'(Cells - 1))
                            ? S_RD : S_IDLE;
                else n_state = (r_ramp == 16'd0) ? S_WR : S_DIV;
            end
            S_DIV:  if (!dbusy && !dreq.start) n_state = S_WR;
            S_WR: begin
                if (r_func == FuncClear && r_cell != CellW'(Cells - 1)) n_state = S_RD;
                else n_state = S_IDLE;
            end
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if ({1'b0, r_o} != nout - CntW'(1)) n_state = S_RD;
                else n_state = r_fend ? S_EMIT : S_IDLE;
            end
            S_EMIT: if (!r_ovalid && {1'b0, r_o} == nout - CntW'(1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cw = r_cw;
        n_g = r_g;
        n_neg = r_neg;
        n_cell = r_cell;
        n_o = r_o;
        we = 1'b0;
        raddr = r_cell;
        dreq = '0;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                n_cw = '0;
                n_cell = r_cell + CellW'(1);
            end
            S_IDLE: begin
                n_o = '0;
                if (i_func == FuncSample) n_cell = CellW'({i_in_index, 3'd0});
                else if (i_func == FuncSetGain) n_cell = CellW'({i_in_index, i_out_index});
                else n_cell = '0;
            end
            S_CALC: begin
                n_cw = rd;
                if (r_func == FuncSample) begin
                    we = 1'b1;
                    if (rd.left != 16'd0) begin
                        n_g = rd.current[39:16];
                        n_cw.left = rd.left - 16'd1;
                        n_cw.current = 40'(r_cw.current);
                    end else begin
                        n_g = rd.target;
                        n_cw.current = {rd.target, 16'd0};
                    end
                end
            end
            default: ;
        endcase
        if (r_state == S_CALC && r_func != FuncSample) begin
            // retarget: load the new target
            n_cw.target = (r_func == FuncClear) ? 24'sd0 : r_gin;
            n_cw.left = r_ramp;
            n_cw.step = '0;
            n_neg = diff[40];
            dreq.start = (r_ramp != 16'd0) && (n_cw.target != rd.target);
            dreq.dividend = diff[40] ? 41'(-diff) : 41'(diff);
            dreq.divisor = r_ramp;
        end
        if (r_state == S_CALC && r_func == FuncSample && rd.left != 16'd0) begin
            if (41'(rd.current) + 41'(rd.step) > G40Max) n_cw.current = G40Max[39:0];
            else if (41'(rd.current) + 41'(rd.step) < G40Min) n_cw.current = G40Min[39:0];
            else n_cw.current = 40'(41'(rd.current) + 41'(rd.step));
        end
        if (r_state == S_WR) begin
            we = 1'b1;
            if (r_ramp != 16'd0) begin
                if (qs > G40Max) n_cw.step = G40Max[39:0];
                else if (qs < G40Min) n_cw.step = G40Min[39:0];
                else n_cw.step = qs[39:0];
            end
        end
        if (r_state == S_WR || (r_state == S_CALC && n_state == S_RD)) begin
            if (r_func == FuncClear) n_cell = r_cell + CellW'(1);
        end
        if (r_state == S_ACC) begin
            n_o = r_o + 3'd1;
            n_cell = r_cell + CellW'(1);
            if (n_state != S_RD) n_o = '0;
        end
        if (r_state == S_EMIT && !r_ovalid) n_o = r_o + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cell <= '0;
            r_o <= '0;
            r_ramp <= 16'd441;
            r_ins <= 4'd1;
            r_outs <= 4'd1;
            r_ovalid <= 1'b0;
            for (int k = 0; k < MaxOutputs; k++) r_acc[k] <= '0;
        end else begin
            r_state <= n_state;
            r_cell <= n_cell;
            r_o <= n_o;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgRamp: r_ramp <= i_cfg_data;
                    CfgIns:  r_ins <= i_cfg_data[3:0];
                    CfgOuts: r_outs <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                if (acc_sum > AccMax) r_acc[r_o] <= AccMax[47:0];
                else if (acc_sum < AccMin) r_acc[r_o] <= AccMin[47:0];
                else r_acc[r_o] <= acc_sum[47:0];
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_EMIT && !r_ovalid) begin
                r_ovalid <= 1'b1;
                // last result of the frame clears every accumulator
                if ({1'b0, r_o} == nout - CntW'(1)) begin
                    for (int k = 0; k < MaxOutputs; k++) r_acc[k] <= '0;
                end else begin
                    r_acc[r_o] <= '0;
                end
            end
        end
        r_cw <= n_cw;
        r_g <= n_g;
        r_neg <= n_neg;
        if (r_state == S_MUL) r_prod <= (48'(r_smp) * 48'(r_g) + 48'sd524288) >>> 20;
        if (r_state == S_EMIT && !r_ovalid) begin
            r_ch <= r_o;
            r_last <= ({1'b0, r_o} == nout - CntW'(1));
            if (r_acc[r_o] > 48'sd8388607) r_mix <= 24'sd8388607;
            else if (r_acc[r_o] < -48'sd8388608) r_mix <= -24'sd8388608;
            else r_mix <= r_acc[r_o][23:0];
        end
        if (take) begin
            r_func <= i_func;
            r_smp <= i_sample;
            r_gin <= i_gain;
            r_fend <= i_frame_end;
        end
    end

    assign o_valid = r_ovalid;
    assign o_channel = r_ch;
    assign o_mixed_sample = r_mix;
    assign o_last = r_last;

    `RMM_ASSERT(a_no_take_busy, i_clk, i_rst_n, take |-> r_state == S_IDLE, "beat taken while busy")
    `RMM_ASSERT(a_emit_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")
    `RMM_ASSERT(a_div_idle, i_clk, i_rst_n, r_state == S_WR |-> !dbusy, "write before quotient")
    `RMM_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clear pass")
endmodule

// ----- hdl/rmm_ram.sv -----
module rmm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/rmm_div.sv -----
// Restoring divider, one quotient bit per cycle, magnitude only.
module rmm_div import rmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_busy,
    output logic [40:0] o_quot
);
    logic [40:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_d;
    logic [16:0] trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        trial = {r_rem[15:0], r_q[40]};
        if (i_req.start) begin
            n_q = i_req.dividend;
            n_rem = '0;
            n_cnt = 6'd41;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (trial >= {1'b0, r_d}) begin
                n_rem = trial - {1'b0, r_d};
                n_q = {r_q[39:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q = {r_q[39:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_d <= i_req.divisor;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_q;
endmodule
